FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the HSV to RGB converter RTL
// Clocked concurrent checks, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define H2R_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// expression must never be true outside reset
`define H2R_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

FILE: hw/rtl/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg
// Widths, constants and stage payload types of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int unsigned HUE_W  = 15;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned SEC_W  = 3;
  // sized for the largest hue fraction setting (sector up to 61440)
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned PN_W   = 16;
  localparam int unsigned MUL_W  = 24;
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned CNT_W  = 10;  // whole sectors in a 15-bit hue

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;
  localparam int unsigned SEC_PER_CIRCLE = 6;

  // reciprocal multipliers, exact over the operand ranges used here
  localparam logic [13:0] RECIP15      = 14'd8739;     // 2^17 / 15, rounded up
  localparam int unsigned RECIP15_SH   = 17;
  localparam logic [9:0]  RECIP6       = 10'd683;      // 2^12 / 6, rounded up
  localparam int unsigned RECIP6_SH    = 12;
  localparam logic [15:0] RECIP255     = 16'd32897;    // 2^23 / 255, rounded up
  localparam int unsigned RECIP255_SH  = 23;
  localparam logic [20:0] RECIP3825    = 21'd1122868;  // 2^32 / 3825, rounded up
  localparam int unsigned RECIP3825_SH = 32;

  // sector codes, 60 degrees each
  localparam logic [SEC_W-1:0] SEC_R_TO_Y = 3'd0;
  localparam logic [SEC_W-1:0] SEC_Y_TO_G = 3'd1;
  localparam logic [SEC_W-1:0] SEC_G_TO_C = 3'd2;
  localparam logic [SEC_W-1:0] SEC_C_TO_B = 3'd3;
  localparam logic [SEC_W-1:0] SEC_B_TO_M = 3'd4;
  localparam logic [SEC_W-1:0] SEC_M_TO_R = 3'd5;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
  } pix_t;

  typedef struct packed {
    logic [SEC_W-1:0]  sec;
    logic [FRAC_W-1:0] frac;
    logic [CH_W-1:0]   sat;
    logic [CH_W-1:0]   val;
  } sec_stage_t;

  typedef struct packed {
    logic [SEC_W-1:0] sec;
    logic [CH_W-1:0]  val;
    logic [PN_W-1:0]  pnum;
    logic [NUM_W-1:0] qnum;
    logic [NUM_W-1:0] tnum;
  } prod_stage_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

FILE: hw/rtl/h2r_in_if.sv
// ----------------------------------------------------------------------------
// h2r_in_if
// HSV pixel channel: valid/ready handshake with hue, saturation, brightness.
// ----------------------------------------------------------------------------
interface h2r_in_if;
  import h2r_pkg::*;

  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [CH_W-1:0]   saturation;
  logic [CH_W-1:0]   brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

FILE: hw/rtl/h2r_out_if.sv
// ----------------------------------------------------------------------------
// h2r_out_if
// RGB pixel channel: valid/ready handshake with red, green, blue.
// ----------------------------------------------------------------------------
interface h2r_out_if;
  import h2r_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: hw/rtl/h2r_sector.sv
// ----------------------------------------------------------------------------
// h2r_sector
// Two stages: hue to sector count, then sector code and in-sector fraction.
// ----------------------------------------------------------------------------
module h2r_sector #(
  parameter int unsigned HUE_FRAC_BITS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  h2r_pkg::pix_t       in_pix,
  output logic                out_valid,
  input  logic                out_ready,
  output h2r_pkg::sec_stage_t out_sec
);
  import h2r_pkg::*;

  localparam int unsigned SECTOR = 60 * (2 ** HUE_FRAC_BITS);
  localparam int unsigned FULL   = SEC_PER_CIRCLE * SECTOR;

  // stage A: whole sectors = floor(hue / (60 << F)) = floor((hue >> (F+2)) / 15)
  logic             a_vld_r;
  pix_t             a_pix_r;
  logic [CNT_W-1:0] a_cnt_r;
  logic             a_full_r;
  logic             a_en;

  logic [12:0]      hue_q4;
  logic [26:0]      cnt_prod;
  logic [CNT_W-1:0] cnt_nxt;
  logic             full_nxt;

  // stage B
  logic             b_vld_r;
  sec_stage_t       b_sec_r;
  logic             b_en;

  logic [19:0]      d_prod;
  logic [6:0]       turns;
  logic [CNT_W-1:0] turn_cnt;
  logic [31:0]      frac_wide;
  sec_stage_t       sec_nxt;

  assign b_en     = !b_vld_r || out_ready;
  assign a_en     = !a_vld_r || b_en;
  assign in_ready = a_en;

  assign hue_q4   = 13'(in_pix.hue >> (HUE_FRAC_BITS + 2));
  assign cnt_prod = 27'(hue_q4) * 27'(RECIP15);
  assign cnt_nxt  = CNT_W'(cnt_prod >> RECIP15_SH);
  assign full_nxt = (20'(in_pix.hue) == 20'(FULL));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en && in_valid) begin
      a_pix_r  <= in_pix;
      a_cnt_r  <= cnt_nxt;
      a_full_r <= full_nxt;
    end
  end

  // sector = count mod 6, which also wraps hues past the full circle
  assign d_prod    = 20'(a_cnt_r) * 20'(RECIP6);
  assign turns     = 7'(d_prod >> RECIP6_SH);
  assign turn_cnt  = CNT_W'(turns) * CNT_W'(SEC_PER_CIRCLE);
  assign frac_wide = 32'(a_pix_r.hue) - 32'(a_cnt_r) * 32'(SECTOR);

  always_comb begin
    sec_nxt.sat = a_pix_r.sat;
    sec_nxt.val = a_pix_r.val;
    if (a_full_r) begin
      // exactly 360 degrees: last sector, full fraction
      sec_nxt.sec  = SEC_M_TO_R;
      sec_nxt.frac = FRAC_W'(SECTOR);
    end else begin
      sec_nxt.sec  = SEC_W'(a_cnt_r - turn_cnt);
      sec_nxt.frac = frac_wide[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en && a_vld_r) begin
      b_sec_r <= sec_nxt;
    end
  end

  assign out_valid = b_vld_r;
  assign out_sec   = b_sec_r;

endmodule

FILE: hw/rtl/h2r_prod.sv
// ----------------------------------------------------------------------------
// h2r_prod
// Two multiply stages forming the numerators of p, q and t.
// ----------------------------------------------------------------------------
module h2r_prod #(
  parameter int unsigned HUE_FRAC_BITS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  h2r_pkg::sec_stage_t  in_sec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output h2r_pkg::prod_stage_t out_prod
);
  import h2r_pkg::*;

  localparam int unsigned SECTOR = 60 * (2 ** HUE_FRAC_BITS);
  localparam int unsigned DEN    = SECTOR * 255;

  // stage C: v*(255-s), frac*s, (sector-frac)*s
  logic             c_vld_r;
  logic [SEC_W-1:0] c_sec_r;
  logic [CH_W-1:0]  c_val_r;
  logic [PN_W-1:0]  c_pnum_r;
  logic [MUL_W-1:0] c_qs_r;
  logic [MUL_W-1:0] c_ts_r;
  logic             c_en;

  logic [PN_W-1:0]  pnum_nxt;
  logic [MUL_W-1:0] qs_nxt;
  logic [MUL_W-1:0] ts_nxt;

  // stage D: v*(den - x*s)
  logic             d_vld_r;
  prod_stage_t      d_prod_r;
  logic             d_en;
  prod_stage_t      prod_nxt;

  assign d_en     = !d_vld_r || out_ready;
  assign c_en     = !c_vld_r || d_en;
  assign in_ready = c_en;

  assign pnum_nxt = PN_W'(in_sec.val) * PN_W'(CH_MAX - in_sec.sat);
  assign qs_nxt   = MUL_W'(in_sec.frac) * MUL_W'(in_sec.sat);
  assign ts_nxt   = MUL_W'(FRAC_W'(SECTOR) - in_sec.frac) * MUL_W'(in_sec.sat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (c_en) begin
      c_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_en && in_valid) begin
      c_sec_r  <= in_sec.sec;
      c_val_r  <= in_sec.val;
      c_pnum_r <= pnum_nxt;
      c_qs_r   <= qs_nxt;
      c_ts_r   <= ts_nxt;
    end
  end

  always_comb begin
    prod_nxt.sec  = c_sec_r;
    prod_nxt.val  = c_val_r;
    prod_nxt.pnum = c_pnum_r;
    prod_nxt.qnum = NUM_W'(c_val_r) * NUM_W'(MUL_W'(DEN) - c_qs_r);
    prod_nxt.tnum = NUM_W'(c_val_r) * NUM_W'(MUL_W'(DEN) - c_ts_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (d_en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_en && c_vld_r) begin
      d_prod_r <= prod_nxt;
    end
  end

  assign out_valid = d_vld_r;
  assign out_prod  = d_prod_r;

endmodule

FILE: hw/rtl/h2r_div.sv
// ----------------------------------------------------------------------------
// h2r_div
// Constant division by reciprocal multiply, then six-way channel routing.
// ----------------------------------------------------------------------------
module h2r_div #(
  parameter int unsigned HUE_FRAC_BITS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  h2r_pkg::prod_stage_t in_prod,
  output logic                 out_valid,
  input  logic                 out_ready,
  output h2r_pkg::rgb_t        out_rgb
);
  import h2r_pkg::*;

  // den = (60 << F) * 255 = 2^(F+2) * 3825
  localparam int unsigned DEN_SH = HUE_FRAC_BITS + 2;

  // stage E: quotients
  logic             e_vld_r;
  logic [SEC_W-1:0] e_sec_r;
  logic [CH_W-1:0]  e_val_r;
  logic [CH_W-1:0]  e_p_r;
  logic [CH_W-1:0]  e_q_r;
  logic [CH_W-1:0]  e_t_r;
  logic             e_en;

  logic [19:0]      q_red;
  logic [19:0]      t_red;
  logic [40:0]      q_prod;
  logic [40:0]      t_prod;
  logic [31:0]      p_prod;

  // stage F: output register
  logic             f_vld_r;
  rgb_t             f_rgb_r;
  logic             f_en;
  rgb_t             rgb_nxt;

  assign f_en     = !f_vld_r || out_ready;
  assign e_en     = !e_vld_r || f_en;
  assign in_ready = e_en;

  assign q_red  = 20'(in_prod.qnum >> DEN_SH);
  assign t_red  = 20'(in_prod.tnum >> DEN_SH);
  assign q_prod = 41'(q_red) * 41'(RECIP3825);
  assign t_prod = 41'(t_red) * 41'(RECIP3825);
  assign p_prod = 32'(in_prod.pnum) * 32'(RECIP255);

  // every quotient is at most v, so the 8-bit select needs no clamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (e_en) begin
      e_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_en && in_valid) begin
      e_sec_r <= in_prod.sec;
      e_val_r <= in_prod.val;
      e_p_r   <= CH_W'(p_prod >> RECIP255_SH);
      e_q_r   <= CH_W'(q_prod >> RECIP3825_SH);
      e_t_r   <= CH_W'(t_prod >> RECIP3825_SH);
    end
  end

  always_comb begin
    case (e_sec_r)
      SEC_R_TO_Y: rgb_nxt = '{red: e_val_r, green: e_t_r,   blue: e_p_r};
      SEC_Y_TO_G: rgb_nxt = '{red: e_q_r,   green: e_val_r, blue: e_p_r};
      SEC_G_TO_C: rgb_nxt = '{red: e_p_r,   green: e_val_r, blue: e_t_r};
      SEC_C_TO_B: rgb_nxt = '{red: e_p_r,   green: e_q_r,   blue: e_val_r};
      SEC_B_TO_M: rgb_nxt = '{red: e_t_r,   green: e_p_r,   blue: e_val_r};
      default:    rgb_nxt = '{red: e_val_r, green: e_p_r,   blue: e_q_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (f_en) begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en && e_vld_r) begin
      f_rgb_r <= rgb_nxt;
    end
  end

  assign out_valid = f_vld_r;
  assign out_rgb   = f_rgb_r;

endmodule

FILE: hw/rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Fixed-point HSV to 8-bit RGB pixel converter, six-stage pipeline.
// ----------------------------------------------------------------------------
// One pixel in and one pixel out per clock when no back-pressure holds the
// output. On the way to the output register two stages find the hue sector
// and fraction, two form the p/q/t numerators with the multipliers, one divides
// by reciprocal multiply and one routes the channels into the output register.
// Every stage carries its own valid bit and ready ripples back stage by stage,
// so bubbles are squeezed out under back-pressure and the input keeps taking
// beats until all six stages hold a pixel. Hue is in units of
// 2^-HUE_FRAC_BITS degree; 360 degrees maps to the same color as 0, and larger
// hues wrap around the circle.
`include "assert_macros.svh"

module hsv_to_rgb_converter #(
  parameter int unsigned HUE_FRAC_BITS = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  h2r_in_if.sink    in_bus,
  h2r_out_if.source out_bus
);
  import h2r_pkg::*;

  pix_t        in_pix;
  logic        sec_vld;
  logic        sec_rdy;
  sec_stage_t  sec_data;
  logic        prod_vld;
  logic        prod_rdy;
  prod_stage_t prod_data;
  rgb_t        rgb;

  assign in_pix = '{hue: in_bus.hue, sat: in_bus.saturation, val: in_bus.brightness};

  h2r_sector #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .in_pix    (in_pix),
    .out_valid (sec_vld),
    .out_ready (sec_rdy),
    .out_sec   (sec_data)
  );

  h2r_prod #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sec_vld),
    .in_ready  (sec_rdy),
    .in_sec    (sec_data),
    .out_valid (prod_vld),
    .out_ready (prod_rdy),
    .out_prod  (prod_data)
  );

  h2r_div #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prod_vld),
    .in_ready  (prod_rdy),
    .in_prod   (prod_data),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_rgb   (rgb)
  );

  assign out_bus.red   = rgb.red;
  assign out_bus.green = rgb.green;
  assign out_bus.blue  = rgb.blue;

  // input can only stall when the output holds a beat that is not taken
  `H2R_ASSERT_NEVER(a_stall_source, clk, rst_n, !in_bus.ready && !(out_bus.valid && !out_bus.ready), "input stalled without output back-pressure")
  // pipeline comes out of reset empty
  `H2R_ASSERT(a_reset_empty, clk, rst_n, $past(!rst_n) |-> !out_bus.valid, "output valid right after reset")

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hsv_to_rgb_converter. Directed hue, saturation
// and brightness corners, then random pixels under three mixes of sender
// and receiver idling. Each accepted output beat is checked against an
// integer HSV to RGB predictor, in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import h2r_pkg::*;

  localparam int unsigned FRAC_BITS   = 6;
  localparam longint unsigned SECTOR  = 64'd60 << FRAC_BITS;
  localparam longint unsigned CIRCLE  = SECTOR * 6;
  localparam longint unsigned DEN     = SECTOR * 255;
  localparam int unsigned STALL_LIMIT = 4000;  // cycles with no beat on either side
  localparam int unsigned TAIL_CYCLES = 16;    // six-stage pipe plus margin

  logic clk;
  logic rst_n;

  h2r_in_if  in_bus ();
  h2r_out_if out_bus ();

  hsv_to_rgb_converter #(.HUE_FRAC_BITS(FRAC_BITS)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  rgb_t        pending_rgb[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned pixels_sent;
  int unsigned pixels_checked;
  int unsigned directed_count;
  int unsigned quiet_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [CH_W-1:0] clamp_ch(longint unsigned x);
    return (x > 255) ? CH_MAX : x[CH_W-1:0];
  endfunction

  // exact integer HSV to RGB, truncating
  function automatic rgb_t hsv_pixel_to_rgb(logic [HUE_W-1:0] hue,
                                            logic [CH_W-1:0] sat,
                                            logic [CH_W-1:0] val);
    longint unsigned h, s, v, frac, p, q, t, r, g, b;
    logic [SEC_W-1:0] sec;
    rgb_t             px;
    h = 64'(hue);
    s = 64'(sat);
    v = 64'(val);
    if (h > CIRCLE) h = h % CIRCLE;
    sec  = SEC_W'(h / SECTOR);
    frac = h % SECTOR;
    // 360 degrees stays in the last sector with a full fraction
    if (h / SECTOR >= SEC_PER_CIRCLE) begin
      sec  = SEC_M_TO_R;
      frac = SECTOR;
    end
    p = v * (255 - s) / 255;
    q = v * (DEN - frac * s) / DEN;
    t = v * (DEN - (SECTOR - frac) * s) / DEN;
    case (sec)
      SEC_R_TO_Y: begin r = v; g = t; b = p; end
      SEC_Y_TO_G: begin r = q; g = v; b = p; end
      SEC_G_TO_C: begin r = p; g = v; b = t; end
      SEC_C_TO_B: begin r = p; g = q; b = v; end
      SEC_B_TO_M: begin r = t; g = p; b = v; end
      default:    begin r = v; g = p; b = q; end
    endcase
    px.red   = clamp_ch(r);
    px.green = clamp_ch(g);
    px.blue  = clamp_ch(b);
    return px;
  endfunction

  task automatic send_pixel(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                            logic [CH_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.hue        <= hue;
    in_bus.saturation <= sat;
    in_bus.brightness <= val;
    do @(posedge clk); while (!in_bus.ready);
    pending_rgb.push_back(hsv_pixel_to_rgb(hue, sat, val));
    pixels_sent++;
  endtask

  task automatic test_sector_edges();
    for (int k = 0; k < SEC_PER_CIRCLE; k++) begin
      send_pixel(HUE_W'(k * SECTOR), CH_MAX, CH_MAX);
      send_pixel(HUE_W'(k * SECTOR + SECTOR - 1), CH_MAX, 8'd200);
    end
  endtask

  task automatic test_full_circle();
    send_pixel(HUE_W'(CIRCLE), CH_MAX, CH_MAX);
    send_pixel(HUE_W'(CIRCLE), 8'd128, 8'd200);
    send_pixel(HUE_W'(CIRCLE - 1), 8'd77, 8'd255);
  endtask

  task automatic test_hue_wrap();
    send_pixel(HUE_W'(CIRCLE + 1), 8'd200, 8'd255);
    send_pixel(HUE_W'(CIRCLE + SECTOR), CH_MAX, 8'd170);
    send_pixel({HUE_W{1'b1}}, 8'd99, 8'd231);
  endtask

  task automatic test_channel_extremes();
    send_pixel(HUE_W'(5000), 8'd0, CH_MAX);
    send_pixel(HUE_W'(5000), CH_MAX, 8'd0);
    send_pixel(HUE_W'(0), 8'd0, 8'd0);
    send_pixel(HUE_W'(13000), 8'd1, 8'd1);
    send_pixel(HUE_W'(21000), 8'd170, 8'd85);
  endtask

  task automatic test_random(int unsigned count);
    int unsigned hue, sat, val, pick;
    repeat (count) begin
      pick = $urandom_range(9);
      if (pick <= 5) begin
        hue = $urandom_range(32'(CIRCLE));
      end else if (pick == 6) begin
        // right around a sector boundary
        hue = 32'($urandom_range(SEC_PER_CIRCLE) * SECTOR);
        hue = (hue == 0) ? $urandom_range(1) : hue - 1 + $urandom_range(2);
      end else if (pick == 7) begin
        hue = 32'(CIRCLE) - $urandom_range(2);
      end else if (pick == 8) begin
        hue = $urandom_range((1 << HUE_W) - 1, 32'(CIRCLE) + 1);
      end else begin
        hue = $urandom_range((1 << HUE_W) - 1);
      end
      sat = ($urandom_range(7) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
      val = ($urandom_range(7) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
      send_pixel(HUE_W'(hue), CH_W'(sat), CH_W'(val));
    end
  endtask

  // receiver back-pressure
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_rgb.size() == 0) begin
        $display("%0t: unexpected beat, got r=%0d g=%0d b=%0d", $time,
                 out_bus.red, out_bus.green, out_bus.blue);
        mismatches++;
      end else begin
        want = pending_rgb.pop_front();
        pixels_checked++;
        if (out_bus.red !== want.red) begin
          $display("%0t: red expected %0d got %0d", $time, want.red, out_bus.red);
          mismatches++;
        end
        if (out_bus.green !== want.green) begin
          $display("%0t: green expected %0d got %0d", $time, want.green, out_bus.green);
          mismatches++;
        end
        if (out_bus.blue !== want.blue) begin
          $display("%0t: blue expected %0d got %0d", $time, want.blue, out_bus.blue);
          mismatches++;
        end
      end
    end
  end

  // watchdog: no beat on either side for too long
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.hue        = '0;
    in_bus.saturation = '0;
    in_bus.brightness = '0;
    send_idle_pct     = 26;
    recv_idle_pct     = 67;
    mismatches        = 0;
    pixels_sent       = 0;
    pixels_checked    = 0;
    quiet_cycles      = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sector_edges();
    test_full_circle();
    test_hue_wrap();
    test_channel_extremes();
    directed_count = pixels_sent;

    test_random(150);
    send_idle_pct = 67;
    recv_idle_pct = 26;
    test_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150);

    in_bus.valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d of %0d pixels (%0d directed): all sectors, boundaries,",
             pixels_checked, pixels_sent, directed_count);
    $display("360 degree and wrapped hues, under three sender/receiver idle mixes");
    if (mismatches == 0 && pixels_checked == pixels_sent) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/h2r_pkg.sv
hw/rtl/h2r_in_if.sv
hw/rtl/h2r_out_if.sv
hw/rtl/h2r_sector.sv
hw/rtl/h2r_prod.sv
hw/rtl/h2r_div.sv
hw/rtl/hsv_to_rgb_converter.sv
tb/sv/tb.sv
